>>> rtl/rtc_pkg.sv
// Package: shared widths, constants and the beat carried along the divider chain.
`default_nettype none
package rtc_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned REM_W = 2 * CHAN_W;
  localparam int unsigned NUM_CELLS = CHAN_W;

  localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

  // Channel slots within the beat
  localparam int unsigned CH_CYAN = 0;
  localparam int unsigned CH_MAGENTA = 1;
  localparam int unsigned CH_YELLOW = 2;

  typedef struct packed {
    logic [CHAN_W-1:0]                 divisor;
    logic [NUM_CHAN-1:0][REM_W-1:0]    rem;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]   quo;
    logic [CHAN_W-1:0]                 key;
  } rtc_beat_t;

endpackage
`default_nettype wire

>>> rtl/rtc_front.sv
// Front stage: find the peak channel, form key, divisor and scaled numerators.
`default_nettype none
module rtc_front import rtc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CHAN_W-1:0] red,
  input  wire logic [CHAN_W-1:0] green,
  input  wire logic [CHAN_W-1:0] blue,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rtc_beat_t              out_beat
);

  logic [CHAN_W-1:0] peak;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;
  rtc_beat_t beat_next;

  always_comb begin
    logic [CHAN_W-1:0] diff;
    chan[CH_CYAN]    = red;
    chan[CH_MAGENTA] = green;
    chan[CH_YELLOW]  = blue;
    peak = red;
    if (green > peak) peak = green;
    if (blue > peak) peak = blue;
    // A black pixel divides zero by one, so every quotient comes out zero
    beat_next.divisor = (peak == '0) ? CHAN_W'(1) : peak;
    beat_next.key = FULL_SCALE - peak;
    for (int c = 0; c < NUM_CHAN; c++) begin
      diff = peak - chan[c];
      // diff * 255 as diff * 256 - diff
      beat_next.rem[c] = {diff, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, diff};
      beat_next.quo[c] = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rtc_cell.sv
// Divider cell: settle one quotient bit for all three channels.
`default_nettype none
module rtc_cell import rtc_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rtc_beat_t in_beat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rtc_beat_t      out_beat
);

  logic [REM_W-1:0] shifted;
  rtc_beat_t beat_next;

  assign shifted = {{CHAN_W{1'b0}}, in_beat.divisor} << BIT;

  always_comb begin
    beat_next = in_beat;
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (in_beat.rem[c] >= shifted) begin
        beat_next.rem[c] = in_beat.rem[c] - shifted;
        beat_next.quo[c][BIT] = 1'b1;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rgb_to_cmyk_pixel.sv
// Top level: RGB to CMYK pixel converter built as a chain of divider cells.
//
// Usage:
//   Pixel channel (pix_valid/pix_ready, red/green/blue) takes one beat per
//   clock while pix_ready is high. Result channel (cmyk_valid/cmyk_ready,
//   cyan/magenta/yellow/key) gives one beat for every pixel, in order.
//   key = 255 - max(r,g,b); each colour = floor((max - chan) * 255 / max).
//   A black pixel gives cyan, magenta and yellow of 0 and key of 255.
// Structure: one front stage (peak, key, numerators) and eight cells,
//   each settling one quotient bit by a 16-bit compare and subtract per
//   channel.
// Throughput: one pixel per cycle while cmyk_ready is high, set by the one-bit-per-cell chain.
// Stall: each stage holds its beat while the next is full and blocked, and
//   takes a new one as soon as it drains, so bubbles close up; pix_ready
//   drops only when every stage is occupied and the receiver stalls.
// Reset: rst (synchronous, active high) drops every beat in flight.
`default_nettype none
module rgb_to_cmyk_pixel import rtc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pix_valid,
  output logic                   pix_ready,
  input  wire logic [CHAN_W-1:0] red,
  input  wire logic [CHAN_W-1:0] green,
  input  wire logic [CHAN_W-1:0] blue,
  output logic                   cmyk_valid,
  input  wire logic              cmyk_ready,
  output logic [CHAN_W-1:0]      cyan,
  output logic [CHAN_W-1:0]      magenta,
  output logic [CHAN_W-1:0]      yellow,
  output logic [CHAN_W-1:0]      key
);

  // Link k joins stage k to stage k+1; link 0 leaves the front stage
  logic      link_valid [NUM_CELLS+1];
  logic      link_ready [NUM_CELLS+1];
  rtc_beat_t link_beat  [NUM_CELLS+1];

  rtc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_valid),
    .in_ready  (pix_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_beat  (link_beat[0])
  );

  // Settle quotient bits from most significant down
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    rtc_cell #(
      .BIT (NUM_CELLS - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_beat   (link_beat[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_beat  (link_beat[k+1])
    );
  end

  assign link_ready[NUM_CELLS] = cmyk_ready;
  assign cmyk_valid = link_valid[NUM_CELLS];
  assign cyan       = link_beat[NUM_CELLS].quo[CH_CYAN];
  assign magenta    = link_beat[NUM_CELLS].quo[CH_MAGENTA];
  assign yellow     = link_beat[NUM_CELLS].quo[CH_YELLOW];
  assign key        = link_beat[NUM_CELLS].key;

`ifndef SYNTHESIS
  // The peak channel always divides to zero
  a_one_zero: assert property (@(posedge clk) disable iff (rst)
    cmyk_valid |-> (cyan == '0 || magenta == '0 || yellow == '0))
    else $error("no colour component is zero");

  // Black pixel gives no colour
  a_black: assert property (@(posedge clk) disable iff (rst)
    (cmyk_valid && key == FULL_SCALE) |-> (cyan == '0 && magenta == '0 && yellow == '0))
    else $error("black pixel carries colour");

  // Input may only be refused when the result side is stalled
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> (cmyk_valid && !cmyk_ready))
    else $error("pixel refused without output stall");
`endif

endmodule
`default_nettype wire

>>> test/tb_rgb_to_cmyk_pixel.sv
// Testbench: RGB to CMYK pixel converter, self-checking against a built-in colour predictor.
`default_nettype none
module tb_rgb_to_cmyk_pixel;
  import rtc_pkg::*;

  // One CMYK beat as the result channel shows it
  typedef struct packed {
    logic [CHAN_W-1:0] c;
    logic [CHAN_W-1:0] m;
    logic [CHAN_W-1:0] y;
    logic [CHAN_W-1:0] k;
  } cmyk_t;

  // One row of the directed stimulus; 'typed' marks a result written in by hand
  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic              typed;
    cmyk_t             want;
  } pixel_row_t;

  localparam int NUM_DIRECTED = 18;
  localparam int RANDOM_PER_PHASE = 500;
  localparam int LONG_HOLD = 64;
  localparam int PEND_DEPTH = 16;

  // Corners, primaries and the black pixel carry their results as written;
  // the rest are left to the predictor.
  localparam pixel_row_t DIRECTED_PIXELS [NUM_DIRECTED] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   8'd255}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd0}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd255, 8'd0}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{8'd255, 8'd0,   8'd255, 8'd0}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd0,   8'd0}},
    '{8'd1,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd255, 8'd254}},
    '{8'd0,   8'd1,   8'd0,   1'b1, '{8'd255, 8'd0,   8'd255, 8'd254}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{8'd0,   8'd0,   8'd0,   8'd254}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd255, 8'd0}},
    '{8'd128, 8'd64,  8'd32,  1'b0, '0},
    '{8'd254, 8'd1,   8'd0,   1'b0, '0},
    '{8'd85,  8'd170, 8'd255, 1'b0, '0},
    '{8'd170, 8'd85,  8'd1,   1'b0, '0},
    '{8'd1,   8'd2,   8'd3,   1'b0, '0},
    '{8'd200, 8'd199, 8'd1,   1'b0, '0},
    '{8'd127, 8'd128, 8'd129, 1'b0, '0},
    '{8'd255, 8'd254, 8'd253, 1'b0, '0},
    '{8'd2,   8'd1,   8'd0,   1'b0, '0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              pix_valid = 1'b0;
  logic              pix_ready;
  logic [CHAN_W-1:0] red = '0;
  logic [CHAN_W-1:0] green = '0;
  logic [CHAN_W-1:0] blue = '0;
  logic              cmyk_valid;
  logic              cmyk_ready = 1'b0;
  logic [CHAN_W-1:0] cyan;
  logic [CHAN_W-1:0] magenta;
  logic [CHAN_W-1:0] yellow;
  logic [CHAN_W-1:0] key;

  // Expected result riding alongside the pixel on offer
  cmyk_t offer_cmyk = '0;
  // Results still owed by the block, oldest first, kept in a ring
  cmyk_t pending_cmyk [PEND_DEPTH];
  int    pend_wr = 0;
  int    pend_rd = 0;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long receiver hold: the stimulus flips hold_flip, the receiver counts it out
  logic hold_flip = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  rgb_to_cmyk_pixel dut (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .cmyk_valid (cmyk_valid),
    .cmyk_ready (cmyk_ready),
    .cyan       (cyan),
    .magenta    (magenta),
    .yellow     (yellow),
    .key        (key)
  );

  always #2 clk = ~clk;

  // Colour predictor: key from the brightest channel, each colour as the
  // scaled shortfall of its channel below that peak. A black pixel has no
  // peak to divide by, so it gives no colour and full key.
  function automatic cmyk_t cmyk_of(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                    logic [CHAN_W-1:0] b);
    int unsigned peak;
    cmyk_t       res;
    peak = r;
    if (g > peak) begin
      peak = g;
    end
    if (b > peak) begin
      peak = b;
    end
    res.k = FULL_SCALE - CHAN_W'(peak);
    if (peak == 0) begin
      res.c = '0;
      res.m = '0;
      res.y = '0;
    end else begin
      res.c = CHAN_W'(((peak - r) * FULL_SCALE) / peak);
      res.m = CHAN_W'(((peak - g) * FULL_SCALE) / peak);
      res.y = CHAN_W'(((peak - b) * FULL_SCALE) / peak);
    end
    return res;
  endfunction

  // Pick a pixel: mostly uniform, with a share of dark pixels (small peaks
  // stress the division), of tied channels and of saturated channels.
  task automatic rand_pixel(output logic [CHAN_W-1:0] r, output logic [CHAN_W-1:0] g,
                            output logic [CHAN_W-1:0] b);
    r = CHAN_W'($urandom_range(255));
    g = CHAN_W'($urandom_range(255));
    b = CHAN_W'($urandom_range(255));
    case ($urandom_range(9))
      0: begin
        r = CHAN_W'($urandom_range(3));
        g = CHAN_W'($urandom_range(3));
        b = CHAN_W'($urandom_range(3));
      end
      1: begin
        g = r;
      end
      2: begin
        b = FULL_SCALE;
      end
      default: begin
      end
    endcase
  endtask

  // Offer one pixel, idling beforehand at the sender's rate; return at the
  // edge where it is taken, leaving valid high for the caller.
  task automatic offer_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b, input cmyk_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid  <= 1'b1;
    red        <= r;
    green      <= g;
    blue       <= b;
    offer_cmyk <= want;
    @(posedge clk);
    while (!pix_ready) begin
      @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic wait_drained();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pend_wr != pend_rd) begin
      @(posedge clk);
    end
  endtask

  task automatic random_phase(input int sender_pct, input int receiver_pct);
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      rand_pixel(r, g, b);
      offer_pixel(r, g, b, cmyk_of(r, g, b));
    end
  endtask

  task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Receiver: stall at random, or hold off for a long stretch on request
  always @(posedge clk) begin
    if (hold_flip != hold_seen) begin
      hold_seen  <= hold_flip;
      hold_left  <= LONG_HOLD;
      cmyk_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      cmyk_ready <= 1'b0;
    end else begin
      cmyk_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Scoreboard: log each accepted pixel's result before checking the output
  // beat of the same edge, then match the output against the oldest one.
  always @(posedge clk) begin : scoreboard
    cmyk_t want;
    if (!rst && pix_valid && pix_ready) begin
      pending_cmyk[pend_wr % PEND_DEPTH] = offer_cmyk;
      pend_wr++;
    end
    if (!rst && cmyk_valid && cmyk_ready) begin
      if (pend_wr == pend_rd) begin
        errors++;
        $display("%0t: result beat with no pixel pending, expected none, got %0d %0d %0d %0d",
                 $time, cyan, magenta, yellow, key);
      end else begin
        want = pending_cmyk[pend_rd % PEND_DEPTH];
        pend_rd++;
        check_field("cyan", want.c, cyan);
        check_field("magenta", want.m, magenta);
        check_field("yellow", want.y, yellow);
        check_field("key", want.k, key);
      end
    end
  end

  initial begin : stimulus
    cmyk_t want;
    // Hold reset at the start, then release it for good
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels: sender idles lightly, receiver stalls heavily
    send_idle_pct = 10;
    recv_idle_pct = 71;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      want = DIRECTED_PIXELS[i].typed ? DIRECTED_PIXELS[i].want
             : cmyk_of(DIRECTED_PIXELS[i].r, DIRECTED_PIXELS[i].g, DIRECTED_PIXELS[i].b);
      offer_pixel(DIRECTED_PIXELS[i].r, DIRECTED_PIXELS[i].g, DIRECTED_PIXELS[i].b, want);
    end
    // Pause the sender until the pipeline is empty
    wait_drained();

    random_phase(10, 71);
    random_phase(71, 10);

    // Back-pressure: hold the receiver off for a long stretch while pixels
    // keep coming, so every stage fills and pix_ready drops; then run flat out.
    hold_flip <= ~hold_flip;
    random_phase(0, 0);

    // Drain, then wait on so that any stray beats show
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: end a run that hangs on a handshake
  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
